// ===== rtl/pmu_pkg.sv =====
// ----------------------------------------------------------------------------
// pmu_pkg
// Shared types and constants of the paged memory unit.
// ----------------------------------------------------------------------------
package pmu_pkg;

  localparam int SYSTEM_WORDS = 12288;
  localparam int PAGE_WORDS   = 64;
  localparam int PAGE_SLOTS   = 16;
  localparam int SYS_AW       = $clog2(SYSTEM_WORDS);
  localparam int OFF_W        = $clog2(PAGE_WORDS);
  localparam int SLOT_W       = $clog2(PAGE_SLOTS);
  localparam int PG_AW        = SLOT_W + OFF_W;
  localparam int PAGE_NUM_W   = 32 - OFF_W;
  localparam logic [31:0] SYS_LIMIT = 32'h0000_3000;

  localparam logic [1:0] FUNC_READ  = 2'd0;
  localparam logic [1:0] FUNC_WRITE = 2'd1;
  localparam logic [1:0] FUNC_ALLOC = 2'd2;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_DENIED  = 3'd1;
  localparam logic [2:0] ST_FAULT   = 3'd2;
  localparam logic [2:0] ST_IGNORED = 3'd3;
  localparam logic [2:0] ST_FULL    = 3'd4;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_SYS_RD,
    OP_SYS_WR,
    OP_PG_RD,
    OP_PG_WR
  } op_kind_t;

  typedef struct packed {
    op_kind_t          kind;
    logic [SYS_AW-1:0] sys_addr;
    logic [PG_AW-1:0]  pg_addr;
    logic [31:0]       wdata;
    logic [2:0]        status;
  } op_t;

  typedef enum logic {
    BK_CLEAR,
    BK_RUN
  } back_state_t;

endpackage

// ===== rtl/pmu_ram.sv =====
// ----------------------------------------------------------------------------
// pmu_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module pmu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/pmu_queue.sv =====
// ----------------------------------------------------------------------------
// pmu_queue
// Two-entry queue of decoded operations between front and back.
// ----------------------------------------------------------------------------
module pmu_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  pmu_pkg::op_t  push_op,
  input  logic          pop,
  output logic          not_empty,
  output pmu_pkg::op_t  head_op
);
  import pmu_pkg::*;

  op_t        ent_r [2];
  logic       rd_ptr_r, rd_ptr_nxt;
  logic       wr_ptr_r, wr_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  always_comb begin
    rd_ptr_nxt = rd_ptr_r ^ pop;
    wr_ptr_nxt = wr_ptr_r ^ push;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= 1'b0;
      wr_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_op;
    end
  end

  assign not_empty = (count_r != 2'd0);
  assign head_op   = ent_r[rd_ptr_r];

endmodule

// ===== rtl/pmu_front.sv =====
// ----------------------------------------------------------------------------
// pmu_front
// Accepts accesses, matches page slots, checks owner and permission, and
// keeps the slot table.
// ----------------------------------------------------------------------------
module pmu_front (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         accept,
  input  logic [15:0]  context_id,
  input  logic [1:0]   in_func,
  input  logic [31:0]  in_address,
  input  logic [31:0]  in_write_value,
  input  logic [25:0]  in_page_number,
  input  logic [15:0]  in_owner,
  input  logic         in_perm_read,
  input  logic         in_perm_write,
  output logic         push,
  output pmu_pkg::op_t push_op
);
  import pmu_pkg::*;

  logic                  valid_r   [PAGE_SLOTS];
  logic [PAGE_NUM_W-1:0] page_r    [PAGE_SLOTS];
  logic [15:0]           owner_r   [PAGE_SLOTS];
  logic [1:0]            perms_r   [PAGE_SLOTS];

  logic [PAGE_NUM_W-1:0] key;
  logic                  hit, has_free;
  logic [SLOT_W-1:0]     hit_idx, free_idx, slot;
  logic                  take;
  logic [PAGE_NUM_W-1:0] take_page;
  logic [15:0]           take_owner;
  logic [1:0]            take_perms;
  logic [15:0]           s_owner;
  logic [1:0]            s_perms;
  logic [OFF_W-1:0]      off;
  logic                  is_sys, is_own;
  op_t                   op;

  assign off = in_address[OFF_W-1:0];

  always_comb begin
    if (in_func == FUNC_ALLOC) begin
      key = PAGE_NUM_W'(in_page_number);
    end else begin
      key = in_address[31:OFF_W];
    end
    hit      = 1'b0;
    hit_idx  = '0;
    has_free = 1'b0;
    free_idx = '0;
    for (int i = PAGE_SLOTS - 1; i >= 0; i--) begin
      if (valid_r[i] && page_r[i] == key) begin
        hit     = 1'b1;
        hit_idx = SLOT_W'(i);
      end
      if (!valid_r[i]) begin
        has_free = 1'b1;
        free_idx = SLOT_W'(i);
      end
    end
  end

  always_comb begin
    take       = 1'b0;
    take_page  = key;
    take_owner = 16'd0;
    take_perms = 2'b11;
    slot       = hit ? hit_idx : free_idx;
    s_owner    = hit ? owner_r[hit_idx] : 16'd0;
    s_perms    = hit ? perms_r[hit_idx] : 2'b11;
    is_sys     = (context_id == 16'd0);
    is_own     = (context_id == s_owner);
    op.kind     = OP_NONE;
    op.sys_addr = in_address[SYS_AW-1:0];
    op.pg_addr  = {slot, off};
    op.wdata    = in_write_value;
    op.status   = ST_IGNORED;
    if (in_func == FUNC_ALLOC) begin
      if (hit) begin
        op.status = ST_IGNORED;
      end else if (!has_free) begin
        op.status = ST_FULL;
      end else begin
        take       = 1'b1;
        take_owner = in_owner;
        take_perms = {in_perm_write, in_perm_read};
        op.status  = ST_OK;
      end
    end else if (in_func == FUNC_READ || in_func == FUNC_WRITE) begin
      if (in_address[31] || in_address < SYS_LIMIT) begin
        if (!in_address[31] && in_address < 32'(SYSTEM_WORDS)) begin
          op.kind   = (in_func == FUNC_READ) ? OP_SYS_RD : OP_SYS_WR;
          op.status = ST_OK;
        end
      end else if (in_func == FUNC_READ) begin
        op.status = ST_OK;
        if (hit) begin
          if (!is_sys && !is_own) begin
            op.status = ST_DENIED;
          end else begin
            op.kind = OP_PG_RD;
          end
        end
      end else begin
        if (!hit && in_write_value == 32'd0) begin
          op.status = ST_IGNORED;
        end else if (!hit && !has_free) begin
          op.status = ST_FULL;
        end else begin
          take = !hit;
          if (!is_sys && !is_own) begin
            op.status = ST_DENIED;
          end else if (is_own && !s_perms[1]) begin
            op.status = ST_FAULT;
          end else begin
            op.kind   = OP_PG_WR;
            op.status = ST_OK;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PAGE_SLOTS; i++) begin
        valid_r[i] <= 1'b0;
      end
    end else if (accept && take) begin
      valid_r[slot] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && take) begin
      page_r[slot]  <= take_page;
      owner_r[slot] <= take_owner;
      perms_r[slot] <= take_perms;
    end
  end

  assign push    = accept;
  assign push_op = op;

endmodule

// ===== rtl/pmu_back.sv =====
// ----------------------------------------------------------------------------
// pmu_back
// Clears the system and page memories after reset, then carries out queued
// operations on them and presents each result for one cycle.
// ----------------------------------------------------------------------------
module pmu_back (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         q_not_empty,
  input  pmu_pkg::op_t q_head,
  output logic         q_pop,
  output logic         clearing,
  output logic         out_valid,
  output logic [31:0]  out_read_data,
  output logic [2:0]   out_status
);
  import pmu_pkg::*;

  back_state_t       state_r, state_nxt;
  logic [SYS_AW-1:0] clr_r, clr_nxt;
  logic              sys_we, sys_re, pg_we, pg_re;
  logic [SYS_AW-1:0] sys_addr;
  logic [PG_AW-1:0]  pg_addr;
  logic [31:0]       sys_wdata, sys_rdata, pg_wdata, pg_rdata;
  logic              done_r, from_sys_r, from_pg_r;
  logic [2:0]        status_r;

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    q_pop     = 1'b0;
    sys_we    = 1'b0;
    sys_re    = 1'b0;
    pg_we     = 1'b0;
    pg_re     = 1'b0;
    sys_addr  = q_head.sys_addr;
    sys_wdata = q_head.wdata;
    pg_addr   = q_head.pg_addr;
    pg_wdata  = q_head.wdata;
    unique case (state_r)
      BK_CLEAR: begin
        sys_we    = 1'b1;
        sys_addr  = clr_r;
        sys_wdata = 32'd0;
        pg_we     = (clr_r < SYS_AW'(PAGE_SLOTS * PAGE_WORDS));
        pg_addr   = clr_r[PG_AW-1:0];
        pg_wdata  = 32'd0;
        clr_nxt   = clr_r + SYS_AW'(1);
        if (clr_r == SYS_AW'(SYSTEM_WORDS - 1)) begin
          state_nxt = BK_RUN;
        end
      end
      BK_RUN: begin
        q_pop  = q_not_empty;
        sys_we = q_not_empty && q_head.kind == OP_SYS_WR;
        sys_re = q_not_empty && q_head.kind == OP_SYS_RD;
        pg_we  = q_not_empty && q_head.kind == OP_PG_WR;
        pg_re  = q_not_empty && q_head.kind == OP_PG_RD;
      end
      default: state_nxt = BK_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_CLEAR;
      clr_r   <= '0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      done_r  <= q_pop;
    end
  end

  always_ff @(posedge clk) begin
    from_sys_r <= sys_re;
    from_pg_r  <= pg_re;
    status_r   <= q_head.status;
  end

  pmu_ram #(.WIDTH(32), .DEPTH(SYSTEM_WORDS)) u_sys_ram (
    .clk   (clk),
    .we    (sys_we),
    .re    (sys_re),
    .addr  (sys_addr),
    .wdata (sys_wdata),
    .rdata (sys_rdata)
  );

  pmu_ram #(.WIDTH(32), .DEPTH(PAGE_SLOTS * PAGE_WORDS)) u_page_ram (
    .clk   (clk),
    .we    (pg_we),
    .re    (pg_re),
    .addr  (pg_addr),
    .wdata (pg_wdata),
    .rdata (pg_rdata)
  );

  assign clearing      = (state_r == BK_CLEAR);
  assign out_valid     = done_r;
  assign out_status    = status_r;
  assign out_read_data = from_sys_r ? sys_rdata : (from_pg_r ? pg_rdata : 32'd0);

endmodule

// ===== rtl/paged_memory_unit_with_owner_check_core.sv =====
// ----------------------------------------------------------------------------
// paged_memory_unit_with_owner_check_core
// Paged memory unit with owner check: system memory, page slot table and
// owner and permission checks behind a command interface.
// ----------------------------------------------------------------------------
// After reset the unit holds busy high while it clears system memory, one
// word a cycle, and page memory alongside it; configuration writes are taken
// during that time. Each access is decoded against the slot table at accept
// and pushed into a queue; the back end then pops it and performs the memory
// access, and the result beat is shown in the cycle after that access, from
// the registered read of the memory. Busy stays high through the result beat,
// so a new access is accepted only after the previous result; results cannot
// be stalled.
module paged_memory_unit_with_owner_check_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_func,
  input  logic [31:0] in_address,
  input  logic [31:0] in_write_value,
  input  logic [25:0] in_page_number,
  input  logic [15:0] in_owner,
  input  logic        in_perm_read,
  input  logic        in_perm_write,
  output logic        out_valid,
  output logic [31:0] out_read_data,
  output logic [2:0]  out_status
);
  import pmu_pkg::*;

  logic [15:0] context_id_r;
  logic        inflight_r, inflight_nxt;
  logic        accept, clearing, push, pop, q_not_empty;
  op_t         push_op, head_op;

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {16'd0, context_id_r};
  assign accept = start && !busy;
  assign busy   = inflight_r || clearing;

  always_comb begin
    inflight_nxt = inflight_r;
    if (accept) begin
      inflight_nxt = 1'b1;
    end else if (out_valid) begin
      inflight_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      context_id_r <= 16'd0;
      inflight_r   <= 1'b0;
    end else begin
      inflight_r <= inflight_nxt;
      if (psel && penable && pwrite && !paddr[2]) begin
        context_id_r <= pwdata[15:0];
      end
    end
  end

  pmu_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (accept),
    .context_id     (context_id_r),
    .in_func        (in_func),
    .in_address     (in_address),
    .in_write_value (in_write_value),
    .in_page_number (in_page_number),
    .in_owner       (in_owner),
    .in_perm_read   (in_perm_read),
    .in_perm_write  (in_perm_write),
    .push           (push),
    .push_op        (push_op)
  );

  pmu_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_op   (push_op),
    .pop       (pop),
    .not_empty (q_not_empty),
    .head_op   (head_op)
  );

  pmu_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_not_empty   (q_not_empty),
    .q_head        (head_op),
    .q_pop         (pop),
    .clearing      (clearing),
    .out_valid     (out_valid),
    .out_read_data (out_read_data),
    .out_status    (out_status)
  );

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the paged memory unit with owner check. A
// behavioral copy of the unit (system words, page slots, written marks)
// predicts status and read data for every accepted command beat, and a
// monitor compares each result beat against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
  import pmu_pkg::*;

  localparam int MAX_CYCLES = 400000;

  typedef struct {
    logic [31:0] data;
    logic [2:0]  status;
  } mem_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_func = '0;
  logic [31:0] in_address = '0, in_write_value = '0;
  logic [25:0] in_page_number = '0;
  logic [15:0] in_owner = '0;
  logic        in_perm_read = 1'b0, in_perm_write = 1'b0;
  logic        out_valid;
  logic [31:0] out_read_data;
  logic [2:0]  out_status;

  logic [31:0] sys_mem [SYSTEM_WORDS];
  logic        pg_valid [PAGE_SLOTS];
  logic [25:0] pg_num [PAGE_SLOTS];
  logic [15:0] pg_owner [PAGE_SLOTS];
  logic [1:0]  pg_perms [PAGE_SLOTS];
  logic [31:0] pg_mem [PAGE_SLOTS*PAGE_WORDS];
  logic [63:0] pg_written [PAGE_SLOTS];
  logic [15:0] cur_context;

  mem_result_t pending_results[$];
  int          errors = 0;
  int          beats_sent = 0;
  int          beats_checked = 0;
  int          cycles = 0;
  int          send_idle_pct = 0;

  paged_memory_unit_with_owner_check_core dut (.*);

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYCLES) begin
      $display("Timeout after %0d cycles", cycles);
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    mem_result_t exp_r;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat data=%h status=%0d",
                 $time, out_read_data, out_status);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        beats_checked++;
        if (out_read_data !== exp_r.data) begin
          $display("%0t: read_data expected %h actual %h", $time, exp_r.data,
                   out_read_data);
          errors++;
        end
        if (out_status !== exp_r.status) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_r.status,
                   out_status);
          errors++;
        end
      end
    end
  end

  function automatic int find_page(logic [25:0] page);
    for (int i = 0; i < PAGE_SLOTS; i++)
      if (pg_valid[i] && pg_num[i] == page) return i;
    return -1;
  endfunction

  function automatic int claim_page(logic [25:0] page, logic [15:0] own,
                                    logic [1:0] perms);
    for (int i = 0; i < PAGE_SLOTS; i++)
      if (!pg_valid[i]) begin
        pg_valid[i] = 1'b1;
        pg_num[i] = page;
        pg_owner[i] = own;
        pg_perms[i] = perms;
        pg_written[i] = '0;
        return i;
      end
    return -1;
  endfunction

  function automatic mem_result_t access_memory(logic [1:0] func,
      logic [31:0] addr, logic [31:0] wv, logic [25:0] pnum, logic [15:0] own,
      logic pr, logic pw);
    mem_result_t r;
    int s;
    logic [25:0] page;
    logic [5:0] off;
    r.data = '0;
    r.status = ST_IGNORED;
    page = addr[31:6];
    off = addr[5:0];
    if (func == FUNC_ALLOC) begin
      if (find_page(pnum) >= 0) r.status = ST_IGNORED;
      else if (claim_page(pnum, own, {pw, pr}) < 0) r.status = ST_FULL;
      else r.status = ST_OK;
    end else if (func == FUNC_READ || func == FUNC_WRITE) begin
      if (addr[31] || addr < SYS_LIMIT) begin
        if (!addr[31] && addr < SYSTEM_WORDS) begin
          if (func == FUNC_READ) r.data = sys_mem[addr];
          else sys_mem[addr] = wv;
          r.status = ST_OK;
        end
      end else begin
        s = find_page(page);
        if (func == FUNC_READ) begin
          r.status = ST_OK;
          if (s >= 0) begin
            if (cur_context != 0 && cur_context != pg_owner[s]) r.status = ST_DENIED;
            else if (pg_written[s][off]) r.data = pg_mem[s*PAGE_WORDS+off];
          end
        end else begin
          if (s < 0) begin
            if (wv == 0) r.status = ST_IGNORED;
            else begin
              s = claim_page(page, 16'd0, 2'b11);
              if (s < 0) r.status = ST_FULL;
            end
          end
          if (s >= 0) begin
            if (cur_context != 0 && cur_context != pg_owner[s]) r.status = ST_DENIED;
            else if (cur_context == pg_owner[s] && !pg_perms[s][1]) r.status = ST_FAULT;
            else begin
              pg_mem[s*PAGE_WORDS+off] = wv;
              pg_written[s][off] = 1'b1;
              r.status = ST_OK;
            end
          end
        end
      end
    end
    return r;
  endfunction

  task automatic send_command(logic [1:0] func, logic [31:0] addr,
      logic [31:0] wv, logic [25:0] pnum, logic [15:0] own, logic pr, logic pw);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    in_func <= func;
    in_address <= addr;
    in_write_value <= wv;
    in_page_number <= pnum;
    in_owner <= own;
    in_perm_read <= pr;
    in_perm_write <= pw;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(access_memory(func, addr, wv, pnum, own, pr, pw));
    beats_sent++;
    @(negedge clk);
    start <= 1'b0;
  endtask

  task automatic drain_results();
    while (pending_results.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic write_context(logic [15:0] ctx);
    drain_results();
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= 3'd0;
    pwdata <= {16'd0, ctx};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    cur_context = ctx;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic test_directed();
    write_context(16'd0);
    send_command(FUNC_WRITE, 32'd0, 32'h8000_0001, '0, '0, 1'b0, 1'b0);
    send_command(FUNC_READ, 32'd0, '0, '0, '0, 1'b0, 1'b0);
    send_command(FUNC_WRITE, SYSTEM_WORDS - 1, 32'hFFFF_FFFF, '0, '0, 1'b0, 1'b0);
    send_command(FUNC_READ, SYSTEM_WORDS - 1, '0, '0, '0, 1'b0, 1'b0);
    send_command(FUNC_WRITE, 32'h8000_0000, 32'h1234, '0, '0, 1'b0, 1'b0);
    send_command(FUNC_READ, 32'hFFFF_FFFF, '0, '0, '0, 1'b0, 1'b0);
    send_command(FUNC_READ, 32'h7FFF_FFFF, '0, '0, '0, 1'b0, 1'b0);
    send_command(FUNC_WRITE, 32'h0000_3000, 32'd0, '0, '0, 1'b0, 1'b0);
    send_command(FUNC_WRITE, 32'h0000_3005, 32'h55, '0, '0, 1'b0, 1'b0);
    send_command(FUNC_READ, 32'h0000_3004, '0, '0, '0, 1'b0, 1'b0);
    send_command(FUNC_READ, 32'h0000_3005, '0, '0, '0, 1'b0, 1'b0);
    send_command(FUNC_ALLOC, '0, '0, 26'd192, 16'hFFFF, 1'b1, 1'b0);
    send_command(FUNC_ALLOC, '0, '0, 26'd192, 16'h1, 1'b0, 1'b1);
    send_command(FUNC_ALLOC, '0, '0, 26'h3FF_FFFF, 16'd0, 1'b0, 1'b0);
    send_command(FUNC_WRITE, 32'h0000_3000, 32'h77, '0, '0, 1'b0, 1'b0);
    send_command(FUNC_WRITE, 32'hFFFF_FFC0, 32'h99, '0, '0, 1'b0, 1'b0);
    send_command(2'd3, 32'h3000, 32'h1, '0, '0, 1'b1, 1'b1);
    write_context(16'hFFFF);
    send_command(FUNC_WRITE, 32'h0000_3001, 32'h66, '0, '0, 1'b0, 1'b0);
    send_command(FUNC_READ, 32'h0000_3001, '0, '0, '0, 1'b0, 1'b0);
    send_command(FUNC_WRITE, 32'h0000_3040, 32'h5, '0, '0, 1'b0, 1'b0);
    send_command(FUNC_READ, 32'h0000_3040, '0, '0, '0, 1'b0, 1'b0);
    for (int i = 0; i < 14; i++)
      send_command(FUNC_ALLOC, '0, '0, 26'(1000 + i), 16'(i), 1'b1, 1'b1);
    send_command(FUNC_WRITE, 32'h0010_0000, 32'h1, '0, '0, 1'b0, 1'b0);
  endtask

  task automatic test_random(int n);
    logic [1:0]  func;
    logic [31:0] addr;
    for (int i = 0; i < n; i++) begin
      if (i % 60 == 0) begin
        case ($urandom_range(3))
          0: write_context(16'd0);
          1: write_context(16'hFFFF);
          default: write_context(16'($urandom_range(3)));
        endcase
      end
      func = ($urandom_range(19) == 0) ? 2'd3 : 2'($urandom_range(2));
      case ($urandom_range(4))
        0: addr = $urandom_range(SYSTEM_WORDS - 1);
        1: addr = $urandom();
        2: addr = 32'h3000 + $urandom_range(1023);
        default: addr = 32'h0010_0000 * $urandom_range(20) + $urandom_range(63);
      endcase
      send_command(func, addr, ($urandom_range(4) == 0) ? 32'd0 : $urandom(),
                   ($urandom_range(1)) ? 26'($urandom_range(20) * 16384)
                                       : 26'($urandom()),
                   16'($urandom_range(3)), 1'($urandom()), 1'($urandom()));
    end
  endtask

  initial begin
    cur_context = '0;
    for (int i = 0; i < SYSTEM_WORDS; i++) sys_mem[i] = '0;
    for (int i = 0; i < PAGE_SLOTS; i++) begin
      pg_valid[i] = 1'b0;
      pg_written[i] = '0;
    end
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    send_idle_pct = 29;
    test_random(170);
    send_idle_pct = 70;
    test_random(170);
    send_idle_pct = 0;
    test_random(170);
    drain_results();
    $display("Sent %0d command beats, checked %0d result beats across contexts,",
             beats_sent, beats_checked);
    $display("system, page, allocate and full-table cases.");
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
